FILE: src/hdlcr_pkg.sv
// Shared types and constants for the HDLC frame receiver.
package hdlcr_pkg;

    localparam logic [7:0] FLAG_BYTE  = 8'h7e;
    localparam logic [7:0] ESC_BYTE   = 8'h7d;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam int         ADDR_SHIFT = 4;
    localparam int         ADDR_W     = 4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One operation handed from the front to the back
    typedef struct packed {
        logic       close;     // 1: closing flag, 0: decoded byte
        logic       dangling;  // close with an escape left open
        logic       ovr;       // frame passed the raw length limit
        logic [7:0] data;      // decoded byte (push only)
    } t_op;

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovr;
    } t_res;

endpackage

FILE: src/hdlcr_front.sv
// Front: flag hunt, escape decoding and raw length counting.
module hdlcr_front
    import hdlcr_pkg::*;
#(
    parameter int MAX_RAW = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_q_ready,
    output logic       o_op_we,
    output t_op        o_op
);
    localparam int CNT_W = $clog2(MAX_RAW + 1);

    logic             r_in_sync, n_in_sync;
    logic             r_esc, n_esc;
    logic             r_ovr, n_ovr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic accept;
    logic is_flag;
    logic is_esc;

    assign o_ready = i_q_ready;
    assign accept  = i_valid & i_q_ready;
    assign is_flag = (i_byte == FLAG_BYTE);
    assign is_esc  = (i_byte == ESC_BYTE);

    // Classify the byte and form the operation
    always_comb begin
        n_in_sync   = r_in_sync;
        n_esc       = r_esc;
        n_ovr       = r_ovr;
        n_cnt       = r_cnt;
        o_op_we     = 1'b0;
        o_op.close    = 1'b0;
        o_op.dangling = r_esc;
        o_op.ovr      = r_ovr;
        o_op.data     = i_byte;
        if (accept) begin
            if (is_flag) begin
                o_op_we    = r_in_sync && (r_cnt != '0);
                o_op.close = 1'b1;
                n_in_sync  = 1'b1;
                n_esc      = 1'b0;
                n_ovr      = 1'b0;
                n_cnt      = '0;
            end else if (r_in_sync) begin
                if (r_cnt == CNT_W'(MAX_RAW)) begin
                    n_ovr = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_esc) begin
                        n_esc     = 1'b0;
                        o_op_we   = 1'b1;
                        o_op.data = i_byte ^ ESC_XOR;
                    end else if (is_esc) begin
                        n_esc = 1'b1;
                    end else begin
                        o_op_we = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sync <= 1'b0;
            r_esc     <= 1'b0;
            r_ovr     <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_in_sync <= n_in_sync;
            r_esc     <= n_esc;
            r_ovr     <= n_ovr;
            r_cnt     <= n_cnt;
        end
    end

endmodule

FILE: src/hdlcr_queue.sv
// Short operation queue between front and back.
module hdlcr_queue
    import hdlcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  t_op               i_op,
    output logic              o_not_full,
    input  logic              i_re,
    output logic              o_not_empty,
    output t_op               o_op,
    output logic [QCNT_W-1:0] o_count
);
    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_wr, do_rd;

    assign o_not_full  = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_op        = r_mem[r_rptr];
    assign o_count     = r_cnt;
    assign do_wr       = i_we & o_not_full;
    assign do_rd       = i_re & o_not_empty;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) r_wptr <= r_wptr + 1'b1;
            if (do_rd) r_rptr <= r_rptr + 1'b1;
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: src/hdlcr_back.sv
// Back: one-byte delay line, address filter and output register.
module hdlcr_back
    import hdlcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_own_addr,
    input  logic              i_op_valid,
    input  t_op               i_op,
    output logic              o_op_pop,
    output logic              o_phase,
    output logic              o_valid,
    input  logic              i_ready,
    output t_res              o_res
);
    logic       r_held_valid, n_held_valid;
    logic [7:0] r_held, n_held;
    logic       r_own, n_own;
    logic       r_phase, n_phase;
    logic       r_out_valid, n_out_valid;
    t_res       r_out, n_out;

    logic       step;
    logic       do_push;
    logic [7:0] push_byte;

    assign step    = i_op_valid & (~r_out_valid | i_ready);
    // A dangling escape first enters the delay line as a literal byte
    assign do_push   = ~i_op.close | (i_op.dangling & ~r_phase);
    assign push_byte = i_op.close ? ESC_BYTE : i_op.data;
    assign o_op_pop  = step & ~(i_op.close & i_op.dangling & ~r_phase);
    assign o_phase   = r_phase;
    assign o_valid   = r_out_valid;
    assign o_res     = r_out;

    // Carry out the head operation
    always_comb begin
        n_held_valid = r_held_valid;
        n_held       = r_held;
        n_own        = r_own;
        n_phase      = r_phase;
        n_out_valid  = r_out_valid & ~i_ready;
        n_out        = r_out;
        if (step) begin
            if (do_push) begin
                if (r_held_valid) begin
                    if (!r_own) begin
                        n_out_valid = 1'b1;
                        n_out       = '{data: r_held, last: 1'b0, ovr: 1'b0};
                    end
                end else begin
                    n_own = (push_byte[7:ADDR_SHIFT] == i_own_addr);
                end
                n_held       = push_byte;
                n_held_valid = 1'b1;
                n_phase      = i_op.close;
            end else begin
                if (r_held_valid && !r_own) begin
                    n_out_valid = 1'b1;
                    n_out       = '{data: r_held, last: 1'b1, ovr: i_op.ovr};
                end
                n_held_valid = 1'b0;
                n_own        = 1'b0;
                n_phase      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_own        <= 1'b0;
            r_phase      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_own        <= n_own;
            r_phase      <= n_phase;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_out  <= n_out;
    end

endmodule

FILE: src/hdlc_frame_receiver.sv
// HDLC frame receiver top level: front, operation queue and back.
// Path: a decoded byte passes the operation queue, is held in the one-byte
// delay line and moves to the output register with the next byte or flag of its frame.
// Throughput: one line byte per cycle while the operation queue has room;
// a dangling close needs an extra back phase, absorbed by the four-entry queue.
// Reset: i_rst_n synchronous active low; clears sync, queue, delay line,
// output valid and own address.
module hdlc_frame_receiver
    import hdlcr_pkg::*;
#(
    parameter int MAX_RAW = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] line_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [7:0] frame_byte
    output logic              o_m_tlast,   // end_of_frame
    output logic              o_m_tuser,   // [0] overrun
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata  // [3:0] own_address
);
    logic [ADDR_W-1:0] r_own_addr;
    logic              op_we, q_not_full, q_not_empty, op_pop, phase;
    t_op               op_in, op_head;
    t_res              res;
    logic [QCNT_W-1:0] q_count;

    // Own address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= '0;
        end else if (i_cfg_we) begin
            r_own_addr <= i_cfg_wdata;
        end
    end

    hdlcr_front #(.MAX_RAW(MAX_RAW)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_q_ready (q_not_full),
        .o_op_we   (op_we),
        .o_op      (op_in)
    );

    hdlcr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (op_we),
        .i_op        (op_in),
        .o_not_full  (q_not_full),
        .i_re        (op_pop),
        .o_not_empty (q_not_empty),
        .o_op        (op_head),
        .o_count     (q_count)
    );

    hdlcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_own_addr (r_own_addr),
        .i_op_valid (q_not_empty),
        .i_op       (op_head),
        .o_op_pop   (op_pop),
        .o_phase    (phase),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_res      (res)
    );

    assign o_m_tdata = res.data;
    assign o_m_tlast = res.last;
    assign o_m_tuser = res.ovr;

    // Queue fill never passes its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("operation queue overfilled");

    // Overrun is only reported on the last byte
    a_ovr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("overrun on a non-last byte");

    // Input is refused only when the queue is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> q_count == QCNT_W'(QUEUE_DEPTH))
        else $error("input stalled with queue space");

    // Second half of a dangling close keeps its operation at the queue head
    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        phase |-> q_not_empty && op_head.close && op_head.dangling)
        else $error("dangling close lost from queue head");

endmodule

FILE: verif/hdlc_frame_receiver_test.sv
// Self-checking testbench for the HDLC frame receiver: directed cases, random line traffic, scoreboard checks.
module hdlc_frame_receiver_test;
    import hdlcr_pkg::*;

    localparam int RAW_LIMIT   = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;

    // Tracks the deframer state and holds the frame bytes still due from the block
    class frame_scoreboard;
        logic [ADDR_W-1:0] own_addr;
        bit                synced;
        bit                esc_open;
        bit                held_ok;
        bit                drop_frame;
        bit                ovr_seen;
        logic [7:0]        held;
        int unsigned       raw_cnt;
        int unsigned       raw_max;
        int                errors;
        t_res              due_q[$];

        function new(int unsigned max_raw);
            raw_max    = max_raw;
            own_addr   = '0;
            synced     = 0;
            esc_open   = 0;
            held_ok    = 0;
            drop_frame = 0;
            ovr_seen   = 0;
            held       = '0;
            raw_cnt    = 0;
            errors     = 0;
        endfunction

        function void set_address(logic [ADDR_W-1:0] a);
            own_addr = a;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void queue_byte(logic [7:0] d, logic last, logic ovr);
            t_res r;
            r.data = d;
            r.last = last;
            r.ovr  = ovr;
            due_q.push_back(r);
        endfunction

        // Decoded byte enters the one-byte delay line; the first one sets the address verdict
        function void push_byte(logic [7:0] d);
            if (held_ok) begin
                if (!drop_frame)
                    queue_byte(held, 1'b0, 1'b0);
            end else begin
                drop_frame = (d[7 -: ADDR_W] == own_addr);
            end
            held    = d;
            held_ok = 1;
        endfunction

        // Called for every accepted line byte
        function void note_line_byte(logic [7:0] c);
            if (c == FLAG_BYTE) begin
                if (synced && raw_cnt != 0) begin
                    // dangling escape is delivered as a literal escape byte
                    if (esc_open)
                        push_byte(ESC_BYTE);
                    if (held_ok && !drop_frame)
                        queue_byte(held, 1'b1, ovr_seen);
                end
                synced     = 1;
                esc_open   = 0;
                held_ok    = 0;
                raw_cnt    = 0;
                drop_frame = 0;
                ovr_seen   = 0;
                return;
            end
            if (!synced)
                return;
            // past the length limit: discard, remember the overrun
            if (raw_cnt >= raw_max) begin
                ovr_seen = 1;
                return;
            end
            raw_cnt++;
            if (esc_open) begin
                esc_open = 0;
                push_byte(c ^ ESC_XOR);
            end else if (c == ESC_BYTE) begin
                esc_open = 1;
            end else begin
                push_byte(c);
            end
        endfunction

        // Called for every accepted output transfer
        function void check_result(logic [7:0] data, logic last, logic ovr);
            t_res e;
            if (due_q.size() == 0) begin
                $error("unexpected frame byte %02h (last %0b, overrun %0b)", data, last, ovr);
                errors++;
                return;
            end
            e = due_q.pop_front();
            if (data !== e.data) begin
                $error("frame_byte mismatch: expected %02h, actual %02h", e.data, data);
                errors++;
            end
            if (last !== e.last) begin
                $error("end_of_frame mismatch: expected %0b, actual %0b", e.last, last);
                errors++;
            end
            if (ovr !== e.ovr) begin
                $error("overrun mismatch: expected %0b, actual %0b", e.ovr, ovr);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic [7:0]        i_s_tdata   = '0;
    logic              i_m_tready  = 1'b1;
    logic              i_cfg_we    = 1'b0;
    logic [ADDR_W-1:0] i_cfg_wdata = '0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [7:0]        o_m_tdata;
    logic              o_m_tlast;
    logic              o_m_tuser;

    frame_scoreboard sb = new(RAW_LIMIT);

    bit          quiet      = 0;
    int unsigned bytes_sent = 0;
    int unsigned sink_stall = 0;
    int unsigned sink_roll;

    hdlc_frame_receiver #(
        .MAX_RAW (RAW_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Hard stop if the run hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side: check each transfer, then pick the next tready with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
            if (quiet) begin
                sink_stall = 0;
                i_m_tready <= 1'b1;
            end else if (sink_stall != 0) begin
                sink_stall--;
                i_m_tready <= 1'b0;
            end else begin
                sink_roll = $urandom_range(0, 99);
                if (sink_roll < 20)
                    sink_stall = $urandom_range(1, 3);
                else if (sink_roll < 23)
                    sink_stall = $urandom_range(10, 40);
                i_m_tready <= 1'b1;
            end
        end
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One line byte transfer, then an optional idle gap
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_line_byte(b);
        bytes_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send a frame byte with stuffing where needed
    task automatic send_stuffed(input logic [7:0] d);
        if (d == FLAG_BYTE || d == ESC_BYTE) begin
            send_byte(ESC_BYTE);
            send_byte(d ^ ESC_XOR);
        end else begin
            send_byte(d);
        end
    endtask

    // One frame, usually of about raw_target line bytes, closed by a flag
    task automatic send_frame(input int unsigned raw_target);
        logic [7:0]  d;
        int unsigned start;
        int unsigned kind;
        start = bytes_sent;
        kind  = $urandom_range(0, 99);
        if (kind < 8) begin
            // empty frame
            send_byte(FLAG_BYTE);
        end else if (kind < 16) begin
            // line noise: raw bytes, flags and escapes land anywhere
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
            send_byte(FLAG_BYTE);
        end else begin
            d = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                d[7 -: ADDR_W] = sb.own_addr;
            send_stuffed(d);
            while (bytes_sent - start < raw_target) begin
                if ($urandom_range(0, 5) == 0)
                    d = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
                else
                    d = 8'($urandom_range(0, 255));
                send_stuffed(d);
            end
            // broken endings: dangling escape or an escape with a random follower
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_byte(ESC_BYTE);
            end else if (kind == 1) begin
                send_byte(ESC_BYTE);
                send_byte(8'($urandom_range(0, 255)));
            end
            send_byte(FLAG_BYTE);
        end
    endtask

    // Let all due bytes arrive, then give the back end time to settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [ADDR_W-1:0] a);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_address(a);
    endtask

    initial begin
        int unsigned      phase_end;
        logic [ADDR_W-1:0] addr;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, own address still at its reset value of zero
        // bytes before the first flag are ignored
        send_byte(8'h41);
        send_byte(ESC_BYTE);
        send_byte(8'h00);
        // empty frame
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        // escaped flag and escaped escape
        send_byte(8'h12);
        send_byte(8'hff);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE ^ ESC_XOR);
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE ^ ESC_XOR);
        send_byte(FLAG_BYTE);
        // frame from our own address is dropped
        send_byte(8'h05);
        send_byte(8'haa);
        send_byte(FLAG_BYTE);
        // dangling escape before the flag
        send_byte(8'ha0);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        // frame holding only a dangling escape
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        // escape applied to a raw escape byte
        send_byte(8'h3c);
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        drain();

        // Random phases, each under its own address setting
        for (int p = 1; p <= 5; p++) begin
            case (p)
                1: addr = '1;
                2: addr = '0;
                4: addr = 4'h7;
                default: addr = ADDR_W'($urandom_range(0, 15));
            endcase
            quiet = (p == 3);
            write_address(addr);
            phase_end = bytes_sent + 30;
            // frames at and past the raw length limit
            if (p == 2)
                send_frame(RAW_LIMIT);
            else if (p == 4)
                send_frame($urandom_range(RAW_LIMIT + 1, RAW_LIMIT + 8));
            while (bytes_sent < phase_end)
                send_frame($urandom_range(1, 14));
            drain();
        end

        if (sb.pending() != 0) begin
            $error("%0d expected frame bytes never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
